FILE: design/mslfo_pkg.sv
// Shared constants, codes and table helpers for the multi-shape LFO.
package mslfo_pkg;

  // Parameter defaults
  localparam int PHASE_BITS_DEF       = 32;
  localparam int SINE_TABLE_BITS_DEF  = 10;
  localparam int MAX_TICK_SAMPLES_DEF = 4096;

  // Port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int TICK_W     = 13;
  localparam int VALUE_W    = 16;
  localparam int SINE_W     = 15;
  localparam int SHAPE_W    = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INCREMENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET    = 2'd2;

  // Wave shapes
  localparam logic [SHAPE_W-1:0] SHAPE_SINE        = 3'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE    = 3'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_SAW_UP      = 3'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_SAW_DOWN    = 3'd3;
  localparam logic [SHAPE_W-1:0] SHAPE_SQUARE      = 3'd4;
  localparam logic [SHAPE_W-1:0] SHAPE_SAMPLE_HOLD = 3'd5;
  localparam logic [SHAPE_W-1:0] SHAPE_SMOOTH_RAND = 3'd6;

  // Random source
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic signed [11:0] STEP_GAIN = 12'sd1638;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // One quarter-wave entry, 32767*sin(pi/2*idx/2^tbits), Q30 Taylor series.
  // Only evaluated at elaboration.
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
                                                   input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] v;
    x    = (HALF_PI_Q30 * 64'(idx)) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    term = ((term * x2) >> 30) / 64'd6;   acc = acc - term;
    term = ((term * x2) >> 30) / 64'd20;  acc = acc + term;
    term = ((term * x2) >> 30) / 64'd42;  acc = acc - term;
    term = ((term * x2) >> 30) / 64'd72;  acc = acc + term;
    term = ((term * x2) >> 30) / 64'd110; acc = acc - term;
    term = ((term * x2) >> 30) / 64'd156; acc = acc + term;
    term = ((term * x2) >> 30) / 64'd210; acc = acc - term;
    v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

  // Clamp to Q1.15
  function automatic logic signed [VALUE_W-1:0] sat16(input logic signed [17:0] v);
    logic signed [VALUE_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[VALUE_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/mslfo_sine_rom.sv
// Quarter-wave sine table with registered read.
module mslfo_sine_rom #(
  parameter int TABLE_BITS = mslfo_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [TABLE_BITS:0]           rd_addr,
  output logic [mslfo_pkg::SINE_W-1:0]  rd_data
);

  localparam int DEPTH = (1 << TABLE_BITS) + 1;

  logic [mslfo_pkg::SINE_W-1:0] rom [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    assign rom[g] = mslfo_pkg::sine_entry(g, TABLE_BITS);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rom[rd_addr];
    end
  end

endmodule

FILE: design/multi_shape_lfo.sv
// Multi-shape phase-accumulator LFO: top level.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//  in      | in_valid/in_stall   | tick_count, restart
//  out     | out_valid/out_stall | lfo_value, new_random
//
// One item per cycle sustained while out is not stalled; an accepted item
// passes the input register, phase/table stage and result register to out.
// The phase multiply-add and the sine table read sit in the middle stage.
// rst clears the phase, held value, config registers and all valid flags; the
// random source returns to its seed. cfg_ready is always high.
// A stall on out holds the result register; in_stall rises only once all
// three stages are full.
module multi_shape_lfo #(
  parameter int PHASE_BITS       = mslfo_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS  = mslfo_pkg::SINE_TABLE_BITS_DEF,
  parameter int MAX_TICK_SAMPLES = mslfo_pkg::MAX_TICK_SAMPLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mslfo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mslfo_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [mslfo_pkg::TICK_W-1:0]          tick_count,
  input  logic                                  restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mslfo_pkg::VALUE_W-1:0]  lfo_value,
  output logic                                  new_random
);

  localparam int CNT_W  = $clog2(MAX_TICK_SAMPLES + 1);
  localparam int SPAN_W = PHASE_BITS + CNT_W;
  localparam int QLEN   = 1 << SINE_TABLE_BITS;
  localparam int ADDR_W = SINE_TABLE_BITS + 1;
  localparam int CMP_W  = 18;

  // Configuration
  logic [mslfo_pkg::SHAPE_W-1:0] wave_shape;
  logic [PHASE_BITS-1:0]         phase_inc;
  logic [PHASE_BITS-1:0]         phase_off;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_shape <= mslfo_pkg::SHAPE_SINE;
      phase_inc  <= '0;
      phase_off  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mslfo_pkg::REG_WAVE_SHAPE:      wave_shape <= cfg_data[mslfo_pkg::SHAPE_W-1:0];
        mslfo_pkg::REG_PHASE_INCREMENT: phase_inc  <= PHASE_BITS'(cfg_data);
        mslfo_pkg::REG_PHASE_OFFSET:    phase_off  <= PHASE_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // Pipeline enables
  logic v1, v2;
  logic en1, en2, en3;

  assign en3      = !out_valid || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  // Stage 1: input register, tick count clamped on entry
  logic [CMP_W-1:0] tick_ext;
  logic [CMP_W-1:0] max_ext;
  logic [CNT_W-1:0] cnt_clamped;
  logic [CNT_W-1:0] cnt1;
  logic             restart1;

  assign tick_ext    = CMP_W'(tick_count);
  assign max_ext     = CMP_W'(MAX_TICK_SAMPLES);
  assign cnt_clamped = (tick_ext > max_ext) ? CNT_W'(max_ext) : CNT_W'(tick_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      cnt1     <= cnt_clamped;
      restart1 <= restart;
    end
  end

  // Stage 2: read phase, advance accumulator, address the table
  logic [PHASE_BITS-1:0]      phase_accum;
  logic [PHASE_BITS-1:0]      w;
  logic [SPAN_W-1:0]          span;
  logic                       draw;
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [ADDR_W-1:0]          rom_addr;
  logic [16:0]                u17;

  assign w        = phase_accum + phase_off;
  assign span     = SPAN_W'(phase_inc) * SPAN_W'(cnt1);
  assign draw     = SPAN_W'(w) < span;
  assign quad     = w[PHASE_BITS-1 -: 2];
  assign idx      = w[PHASE_BITS-3 -: SINE_TABLE_BITS];
  // mirror the table in the second and fourth quadrants
  assign rom_addr = quad[0] ? (ADDR_W'(QLEN) - ADDR_W'(idx)) : ADDR_W'(idx);

  if (PHASE_BITS >= 17) begin : g_u17_sel
    assign u17 = w[PHASE_BITS-1 -: 17];
  end else begin : g_u17_pad
    assign u17 = {w, {(17 - PHASE_BITS){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accum <= '0;
    end else if (en2 && v1) begin
      if (restart1) begin
        phase_accum <= '0;
      end else begin
        phase_accum <= phase_accum + span[PHASE_BITS-1:0];
      end
    end
  end

  logic        restart2;
  logic        draw2;
  logic        neg2;
  logic [16:0] u17_2;
  logic [mslfo_pkg::SINE_W-1:0] sine_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      restart2 <= restart1;
      draw2    <= draw;
      neg2     <= quad[1];
      u17_2    <= u17;
    end
  end

  mslfo_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk     (clk),
    .rd_en   (en2 && v1),
    .rd_addr (rom_addr),
    .rd_data (sine_mag)
  );

  // Stage 3: shape, random source, held value, result register
  logic [15:0]        random_state;
  logic signed [15:0] held_value;
  logic [15:0]        lfsr_next;
  logic signed [15:0] rnd;
  logic signed [27:0] prod;
  logic signed [12:0] step;
  logic signed [16:0] held_sum;
  logic signed [15:0] held_smooth;
  logic [15:0]        u16;
  logic signed [17:0] val;
  logic signed [17:0] sine_s;

  assign lfsr_next   = (random_state >> 1) ^ (random_state[0] ? mslfo_pkg::LFSR_TAPS : 16'h0000);
  assign rnd         = $signed({~lfsr_next[15], lfsr_next[14:0]});
  assign prod        = rnd * mslfo_pkg::STEP_GAIN;
  assign step        = prod[27:15];
  assign held_sum    = $signed({held_value[15], held_value}) + $signed({{4{step[12]}}, step});
  assign held_smooth = mslfo_pkg::sat16($signed({held_sum[16], held_sum}));
  assign u16         = u17_2[16:1];
  assign sine_s      = $signed({3'b000, sine_mag});

  always_comb begin
    case (wave_shape)
      mslfo_pkg::SHAPE_SINE:     val = neg2 ? -sine_s : sine_s;
      mslfo_pkg::SHAPE_TRIANGLE: begin
        if (!u17_2[16]) begin
          val = $signed({1'b0, u17_2}) - 18'sd32768;
        end else begin
          val = 18'sd98304 - $signed({1'b0, u17_2});
        end
      end
      mslfo_pkg::SHAPE_SAW_UP:      val = $signed({2'b00, u16}) - 18'sd32768;
      mslfo_pkg::SHAPE_SAW_DOWN:    val = 18'sd32768 - $signed({2'b00, u16});
      mslfo_pkg::SHAPE_SQUARE:      val = u17_2[16] ? -18'sd32768 : 18'sd32767;
      mslfo_pkg::SHAPE_SAMPLE_HOLD: begin
        val = draw2 ? 18'(rnd) : 18'(held_value);
      end
      mslfo_pkg::SHAPE_SMOOTH_RAND: val = 18'(held_smooth);
      default:                      val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      random_state <= mslfo_pkg::LFSR_SEED;
      held_value   <= '0;
    end else if (en3) begin
      out_valid <= v2;
      if (v2) begin
        if (restart2) begin
          held_value <= '0;
        end else if (wave_shape == mslfo_pkg::SHAPE_SMOOTH_RAND) begin
          random_state <= lfsr_next;
          held_value   <= held_smooth;
        end else if (wave_shape == mslfo_pkg::SHAPE_SAMPLE_HOLD && draw2) begin
          random_state <= lfsr_next;
          held_value   <= rnd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      if (restart2) begin
        lfo_value  <= '0;
        new_random <= 1'b0;
      end else begin
        lfo_value  <= mslfo_pkg::sat16(val);
        new_random <= (wave_shape == mslfo_pkg::SHAPE_SAMPLE_HOLD) && draw2;
      end
    end
  end

endmodule

FILE: design/mslfo_checker.sv
// Port-level checks for the multi-shape LFO, bound to the top level.
module mslfo_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready,
  input logic [mslfo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [mslfo_pkg::CFG_DATA_W-1:0]     cfg_data,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [mslfo_pkg::TICK_W-1:0]         tick_count,
  input logic                                 restart,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [mslfo_pkg::VALUE_W-1:0] lfo_value,
  input logic                                 new_random
);

  // Track the shape as written on the config port
  logic [mslfo_pkg::SHAPE_W-1:0] shape_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_seen <= mslfo_pkg::SHAPE_SINE;
    end else if (cfg_valid && cfg_ready && cfg_index == mslfo_pkg::REG_WAVE_SHAPE) begin
      shape_seen <= cfg_data[mslfo_pkg::SHAPE_W-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(lfo_value) && $stable(new_random))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(tick_count) && $stable(restart))
    else $error("stalled input changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output can drain");

  a_fresh_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_random |-> shape_seen == mslfo_pkg::SHAPE_SAMPLE_HOLD)
    else $error("new random flagged outside sample-and-hold");

endmodule

bind multi_shape_lfo mslfo_checker u_mslfo_checker (.*);
